// ----- hw/rtl/linked_table_key_search_unit_defines.svh -----
// Assertion macros shared by the linked table key search unit.
`ifndef LINKED_TABLE_KEY_SEARCH_UNIT_DEFINES_SVH
`define LINKED_TABLE_KEY_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked on aclk and off while aresetn is low.
`define LTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("linked table search: same-cycle check failed");

// Next-cycle implication, checked on aclk and off while aresetn is low.
`define LTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("linked table search: next-cycle check failed");

`endif

// ----- hw/rtl/lts_pkg.sv -----
// Types, constants and codes shared by the linked table key search unit.
`timescale 1ns / 1ps

package lts_pkg;

    localparam int DEF_ENTRIES = 1024;

    localparam int IDX_W = 10;   // entry_index, list_head and found_index
    localparam int KEY_W = 16;   // each data half
    localparam int PTR_W = 16;   // next pointers and prev_index
    localparam int ENTRY_W = 2 * KEY_W + PTR_W;

    localparam logic [PTR_W-1:0] END_MARK = 16'hFFFF;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        STATUS_WRITE = 2'd0,
        STATUS_FOUND = 2'd1,
        STATUS_MISS  = 2'd2,
        STATUS_ERROR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FINISH
    } state_t;

    // Verdict of the compare unit on one entry.
    typedef struct packed {
        logic match;
        logic at_end;
        logic ptr_bad;
    } cmp_t;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   found;
        logic [PTR_W-1:0]   prev;
    } result_t;

endpackage

// ----- hw/rtl/lts_entry_ram.sv -----
// Entry table: one write port and one registered read port.
`timescale 1ns / 1ps

module lts_entry_ram #(
    parameter int DEPTH  = lts_pkg::DEF_ENTRIES,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [lts_pkg::ENTRY_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [lts_pkg::ENTRY_W-1:0] rd_data
);

    logic [lts_pkg::ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/lts_key_cmp.sv -----
// Compare unit: checks one entry against the key and classifies its next pointer.
`timescale 1ns / 1ps

module lts_key_cmp #(
    parameter int ENTRIES = lts_pkg::DEF_ENTRIES
) (
    input  logic [lts_pkg::ENTRY_W-1:0] entry,
    input  logic [lts_pkg::KEY_W-1:0]   key_high,
    input  logic [lts_pkg::KEY_W-1:0]   key_low,
    output lts_pkg::cmp_t               cmp
);

    logic [lts_pkg::KEY_W-1:0] ent_high;
    logic [lts_pkg::KEY_W-1:0] ent_low;
    logic [lts_pkg::PTR_W-1:0] ent_next;

    // Entries are laid out as {high, low, next}.
    assign ent_high = entry[lts_pkg::ENTRY_W-1 -: lts_pkg::KEY_W];
    assign ent_low  = entry[lts_pkg::PTR_W +: lts_pkg::KEY_W];
    assign ent_next = entry[lts_pkg::PTR_W-1:0];

    assign cmp.match   = (ent_high == key_high) && (ent_low == key_low);
    assign cmp.at_end  = (ent_next == lts_pkg::END_MARK);
    assign cmp.ptr_bad = (ent_next >= lts_pkg::PTR_W'(ENTRIES));

endmodule

// ----- hw/rtl/linked_table_key_search_unit.sv -----
// Top level of the linked table key search unit: sequencer, table and output register.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  s_       | in        | s_tvalid / s_tready  | tuser: cmd; tdata: index, key, next
//  m_       | out       | m_tvalid / m_tready  | tuser: status; tdata: found, prev
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_data: list_head
//
// A write goes from its transfer cycle to the finishing state, at whose end the result
// moves into the output register.
// A search checks one list node per registered table read in the check state, up to
// ENTRIES nodes for a full walk; a bad head goes straight to the finishing state.
// The table has no reset and no clearing pass; only control state and list_head reset.
// The finishing cycle repeats while an earlier result waits on m_tready; a result held in
// the output register does not block the next input transfer.
`timescale 1ns / 1ps
`include "linked_table_key_search_unit_defines.svh"

module linked_table_key_search_unit #(
    parameter int ENTRIES = lts_pkg::DEF_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] entry_index, [25:10] key_high, [41:26] key_low, [57:42] next_index
    input  logic [63:0] s_tdata,
    // [0] cmd
    input  logic [0:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [9:0] found_index, [25:10] prev_index
    output logic [31:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);

    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int IDX_W  = lts_pkg::IDX_W;
    localparam int KEY_W  = lts_pkg::KEY_W;
    localparam int PTR_W  = lts_pkg::PTR_W;

    // Unpacked input fields.
    logic             in_cmd;
    logic [IDX_W-1:0] in_index;
    logic [KEY_W-1:0] in_high;
    logic [KEY_W-1:0] in_low;
    logic [PTR_W-1:0] in_next;

    assign in_cmd   = s_tuser[0];
    assign in_index = s_tdata[9:0];
    assign in_high  = s_tdata[25:10];
    assign in_low   = s_tdata[41:26];
    assign in_next  = s_tdata[57:42];

    // Sequencer state and walk registers.
    lts_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] list_head_reg;
    logic [KEY_W-1:0] key_high_reg, key_high_next;
    logic [KEY_W-1:0] key_low_reg, key_low_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [PTR_W-1:0] prev_reg, prev_next;
    logic [ADDR_W-1:0] steps_reg, steps_next;
    lts_pkg::result_t pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;
    lts_pkg::result_t m_res_reg, m_res_next;

    logic accept;
    logic out_free;
    logic index_ok;
    logic head_ok;
    logic walk_limit;
    logic walk_on;

    logic [PTR_W-1:0]  index_wide;
    logic [PTR_W-1:0]  head_wide;
    logic [PTR_W-1:0]  cur_wide;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] head_addr;
    logic [ADDR_W-1:0] next_addr;

    logic                        wr_en;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [lts_pkg::ENTRY_W-1:0] rd_data;
    lts_pkg::cmp_t               cmp;

    assign s_tready  = (state_reg == lts_pkg::S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign index_wide = PTR_W'(in_index);
    assign head_wide  = PTR_W'(list_head_reg);
    assign cur_wide   = PTR_W'(cur_reg);
    assign index_ok   = (index_wide < PTR_W'(ENTRIES));
    assign head_ok    = (head_wide < PTR_W'(ENTRIES));
    assign wr_addr    = index_wide[ADDR_W-1:0];
    assign head_addr  = head_wide[ADDR_W-1:0];
    assign next_addr  = rd_data[ADDR_W-1:0];

    // The entry being checked is the last one allowed before the walk limit.
    assign walk_limit = (steps_reg == ADDR_W'(ENTRIES - 1));
    assign walk_on    = !cmp.match && !cmp.at_end && !cmp.ptr_bad && !walk_limit;

    lts_entry_ram #(
        .DEPTH  (ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({in_high, in_low, in_next}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The one compare unit, reused on every node of the walk.
    lts_key_cmp #(
        .ENTRIES (ENTRIES)
    ) u_cmp (
        .entry    (rd_data),
        .key_high (key_high_reg),
        .key_low  (key_low_reg),
        .cmp      (cmp)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lts_pkg::S_IDLE: begin
                if (accept) begin
                    if (in_cmd == lts_pkg::CMD_SEARCH && head_ok) begin
                        state_next = lts_pkg::S_CHECK;
                    end else begin
                        state_next = lts_pkg::S_FINISH;
                    end
                end
            end
            lts_pkg::S_CHECK: begin
                if (!walk_on) begin
                    state_next = lts_pkg::S_FINISH;
                end
            end
            lts_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = lts_pkg::S_IDLE;
                end
            end
            default: state_next = lts_pkg::S_IDLE;
        endcase
    end

    // Datapath control and register next values.
    always_comb begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        steps_next    = steps_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_res_next    = m_res_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = head_addr;
        case (state_reg)
            lts_pkg::S_IDLE: begin
                if (accept) begin
                    if (in_cmd == lts_pkg::CMD_WRITE) begin
                        // Writes beyond the table are dropped but still reported.
                        wr_en     = index_ok;
                        pend_next = '{lts_pkg::STATUS_WRITE, '0, '0};
                    end else begin
                        key_high_next = in_high;
                        key_low_next  = in_low;
                        if (head_ok) begin
                            rd_en      = 1'b1;
                            rd_addr    = head_addr;
                            cur_next   = head_addr;
                            prev_next  = lts_pkg::END_MARK;
                            steps_next = '0;
                        end else begin
                            pend_next = '{lts_pkg::STATUS_ERROR, '0, '0};
                        end
                    end
                end
            end
            lts_pkg::S_CHECK: begin
                if (cmp.match) begin
                    pend_next = '{lts_pkg::STATUS_FOUND, cur_wide[IDX_W-1:0], prev_reg};
                end else if (cmp.at_end) begin
                    pend_next = '{lts_pkg::STATUS_MISS, '0, '0};
                end else if (cmp.ptr_bad || walk_limit) begin
                    pend_next = '{lts_pkg::STATUS_ERROR, '0, '0};
                end else begin
                    // Follow the pointer: read the next node straight from this data.
                    rd_en      = 1'b1;
                    rd_addr    = next_addr;
                    prev_next  = cur_wide;
                    cur_next   = next_addr;
                    steps_next = steps_reg + ADDR_W'(1);
                end
            end
            lts_pkg::S_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = pend_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lts_pkg::S_IDLE;
            m_valid_reg   <= 1'b0;
            list_head_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                list_head_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_high_reg <= key_high_next;
        key_low_reg  <= key_low_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        steps_reg    <= steps_next;
        pend_reg     <= pend_next;
        m_res_reg    <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {6'b0, m_res_reg.prev, m_res_reg.found};

    // After its transfer, every item moves on to the check or finishing state, so s_tready drops.
    `LTS_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
    // Results other than a found match carry zero indices.
    `LTS_ASSERT_NOW(a_zero_fields, m_tvalid && (m_tuser != lts_pkg::STATUS_FOUND),
                    m_tdata == '0)
    // A result enters the output register only from the finishing state.
    `LTS_ASSERT_NOW(a_result_source, $rose(m_tvalid), $past(state_reg) == lts_pkg::S_FINISH)

endmodule

// ----- dv/linked_table_key_search_unit_tb.sv -----
// Self-checking testbench for the linked table key search unit.
`timescale 1ns / 1ps

module linked_table_key_search_unit_tb;

    localparam int ENTRIES = lts_pkg::DEF_ENTRIES;
    localparam int IDX_W = lts_pkg::IDX_W;
    localparam int KEY_W = lts_pkg::KEY_W;
    localparam int PTR_W = lts_pkg::PTR_W;
    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 8000;  // well above a full walk of the table
    localparam int ITEM_TARGET = 450;
    localparam int CALM_AFTER = 380;    // no idling on either side in phases begun past this many items

    // One row of the directed part. When typed is set, the row's own answer is expected
    // and the predictor only keeps its table up to date.
    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] khi;
        logic [KEY_W-1:0] klo;
        logic [PTR_W-1:0] nxt;
        bit               typed;
        lts_pkg::status_t status;
        logic [IDX_W-1:0] found;
        logic [PTR_W-1:0] prev;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data = '0;

    // Predictor state: the entry table, which entries were ever written, and the head.
    logic [KEY_W-1:0] node_hi [ENTRIES];
    logic [KEY_W-1:0] node_lo [ENTRIES];
    logic [PTR_W-1:0] node_next [ENTRIES];
    bit               node_written [ENTRIES];
    logic [IDX_W-1:0] list_head = '0;

    lts_pkg::result_t answers_due [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      quiet_cycles = 0;
    int      stall_left = 0;
    bit      idle_on = 1'b1;

    // List 0 -> 1 -> 1023 after reset (head 0), then a bad tail pointer, then cycles.
    stim_row_t directed_rows [20] = '{
        '{lts_pkg::CMD_WRITE,  10'd0,    16'hFFFF, 16'hFFFF, 16'd1,
          1'b1, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        '{lts_pkg::CMD_WRITE,  10'd1,    16'h0000, 16'h0000, 16'd1023,
          1'b1, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        '{lts_pkg::CMD_WRITE,  10'd1023, 16'h1234, 16'hABCD, lts_pkg::END_MARK,
          1'b1, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        // Match on the head: predecessor is the end marker.
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'hFFFF, 16'hFFFF, 16'd0,
          1'b1, lts_pkg::STATUS_FOUND, 10'd0, lts_pkg::END_MARK},
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'h0000, 16'h0000, 16'd0,
          1'b0, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        // The last node of the list must be checked too.
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'h1234, 16'hABCD, 16'd0,
          1'b0, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        // Only one half matches, so these miss.
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'hFFFF, 16'h0000, 16'd0,
          1'b0, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'h0000, 16'hFFFF, 16'd0,
          1'b0, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        // Tail pointer just past the table.
        '{lts_pkg::CMD_WRITE,  10'd1023, 16'h1234, 16'hABCD, 16'd1024,
          1'b1, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'h1234, 16'hABCD, 16'd0,
          1'b0, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'h0001, 16'h0001, 16'd0,
          1'b1, lts_pkg::STATUS_ERROR, 10'd0, 16'd0},
        // Largest pointer that is not the end marker.
        '{lts_pkg::CMD_WRITE,  10'd1023, 16'h1234, 16'hABCD, 16'hFFFE,
          1'b1, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'h8000, 16'h0001, 16'd0,
          1'b1, lts_pkg::STATUS_ERROR, 10'd0, 16'd0},
        // Tail points back to the head: a missing key runs into the walk limit.
        '{lts_pkg::CMD_WRITE,  10'd1023, 16'h1234, 16'hABCD, 16'd0,
          1'b1, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'h0F0F, 16'hF0F0, 16'd0,
          1'b1, lts_pkg::STATUS_ERROR, 10'd0, 16'd0},
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'h1234, 16'hABCD, 16'd0,
          1'b0, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        // Entry 1 points to itself.
        '{lts_pkg::CMD_WRITE,  10'd1,    16'h0000, 16'h0000, 16'd1,
          1'b1, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'h0000, 16'h0000, 16'd0,
          1'b0, lts_pkg::STATUS_WRITE, 10'd0, 16'd0},
        '{lts_pkg::CMD_SEARCH, 10'd0,    16'hAAAA, 16'h5555, 16'd0,
          1'b1, lts_pkg::STATUS_ERROR, 10'd0, 16'd0},
        '{lts_pkg::CMD_WRITE,  10'd512,  16'h5A5A, 16'hA5A5, lts_pkg::END_MARK,
          1'b1, lts_pkg::STATUS_WRITE, 10'd0, 16'd0}
    };

    linked_table_key_search_unit #(.ENTRIES(ENTRIES)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Stores one entry in the predictor table; a write always answers with status write.
    function automatic lts_pkg::result_t store_node(input logic [IDX_W-1:0] idx,
                                                    input logic [KEY_W-1:0] khi, klo,
                                                    input logic [PTR_W-1:0] nxt);
        lts_pkg::result_t answer;
        node_hi[idx] = khi;
        node_lo[idx] = klo;
        node_next[idx] = nxt;
        node_written[idx] = 1'b1;
        answer.status = lts_pkg::STATUS_WRITE;
        answer.found = '0;
        answer.prev = '0;
        return answer;
    endfunction

    // Walks the list from the head for a key. touches_blank flags a walk that reads an
    // entry never written, which the block does not define.
    function automatic lts_pkg::result_t walk_list(input logic [KEY_W-1:0] khi, klo,
                                                   output bit touches_blank);
        lts_pkg::result_t answer;
        int unsigned      cur;
        logic [PTR_W-1:0] prev;
        answer.status = lts_pkg::STATUS_ERROR;
        answer.found = '0;
        answer.prev = '0;
        touches_blank = 1'b0;
        cur = list_head;
        prev = lts_pkg::END_MARK;
        for (int steps = 0; steps < ENTRIES; steps++) begin
            if (cur >= ENTRIES) begin
                return answer;
            end
            if (!node_written[cur]) begin
                touches_blank = 1'b1;
            end
            if (node_hi[cur] == khi && node_lo[cur] == klo) begin
                answer.status = lts_pkg::STATUS_FOUND;
                answer.found = IDX_W'(cur);
                answer.prev = prev;
                return answer;
            end
            if (node_next[cur] == lts_pkg::END_MARK) begin
                answer.status = lts_pkg::STATUS_MISS;
                return answer;
            end
            prev = PTR_W'(cur);
            cur = node_next[cur];
        end
        // Walk limit: ENTRIES nodes were checked without a match or an end marker.
        return answer;
    endfunction

    // Presents one item, with an optional gap before it, and records its answer once
    // the transfer has happened. tvalid stays high afterwards until the next negedge.
    task automatic drive_item(input logic cmd, input logic [IDX_W-1:0] idx,
                              input logic [KEY_W-1:0] khi, klo,
                              input logic [PTR_W-1:0] nxt, input lts_pkg::result_t answer);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'd0, nxt, klo, khi, idx};
        do @(posedge aclk); while (!s_tready);
        answers_due.push_back(answer);
        items_sent++;
    endtask

    task automatic issue_write(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] khi, klo,
                               input logic [PTR_W-1:0] nxt);
        lts_pkg::result_t answer;
        answer = store_node(idx, khi, klo, nxt);
        drive_item(lts_pkg::CMD_WRITE, idx, khi, klo, nxt, answer);
    endtask

    // Searches whose walk would reach an unwritten entry are dropped.
    task automatic issue_search(input logic [KEY_W-1:0] khi, klo);
        lts_pkg::result_t answer;
        bit               blank;
        answer = walk_list(khi, klo, blank);
        if (!blank) begin
            drive_item(lts_pkg::CMD_SEARCH, IDX_W'($urandom), khi, klo, PTR_W'($urandom),
                       answer);
        end
    endtask

    // The head is only changed once every result has been taken.
    task automatic set_head(input logic [IDX_W-1:0] head);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= head;
        do @(posedge aclk); while (!cfg_ready);
        list_head = head;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall bursts while idling is on.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every result transfer is matched against the oldest pending answer.
    always @(posedge aclk) begin
        lts_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: result with none pending: status %0d found %0d prev %h",
                         $time, m_tuser, m_tdata[9:0], m_tdata[25:10]);
                mismatches++;
            end else begin
                want = answers_due.pop_front();
                if (m_tuser !== want.status || m_tdata[9:0] !== want.found
                        || m_tdata[25:10] !== want.prev) begin
                    $display("%0t: expected status %0d found %0d prev %h, got %0d %0d %h",
                             $time, want.status, want.found, want.prev,
                             m_tuser, m_tdata[9:0], m_tdata[25:10]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [IDX_W-1:0] nodes [$];
        logic [31:0]      keys [$];
        int               order [$];
        bit               taken [ENTRIES];
        logic [IDX_W-1:0] head;
        logic [PTR_W-1:0] tail;
        lts_pkg::result_t answer;
        bit               blank;
        int               phase, len, pick, sel, pos, swap, nsearch;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].cmd == lts_pkg::CMD_WRITE) begin
                answer = store_node(directed_rows[r].idx, directed_rows[r].khi,
                                    directed_rows[r].klo, directed_rows[r].nxt);
            end else begin
                answer = walk_list(directed_rows[r].khi, directed_rows[r].klo, blank);
            end
            if (directed_rows[r].typed) begin
                answer.status = directed_rows[r].status;
                answer.found = directed_rows[r].found;
                answer.prev = directed_rows[r].prev;
            end
            drive_item(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].khi,
                       directed_rows[r].klo, directed_rows[r].nxt, answer);
        end

        // Each phase moves the head, builds a fresh list there and searches it.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            idle_on = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            if (phase == 0) begin
                head = IDX_W'(ENTRIES - 1);
            end else if (phase == 1) begin
                head = '0;
            end else begin
                head = IDX_W'($urandom_range(0, ENTRIES - 1));
            end
            set_head(head);

            // Mostly short lists, now and then a long one.
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            nodes.delete();
            keys.delete();
            order.delete();
            foreach (taken[i]) taken[i] = 1'b0;
            nodes.push_back(head);
            taken[head] = 1'b1;
            while (nodes.size() < len) begin
                pick = $urandom_range(0, ENTRIES - 1);
                if (!taken[pick]) begin
                    taken[pick] = 1'b1;
                    nodes.push_back(IDX_W'(pick));
                end
            end
            // Some keys repeat an earlier node so that the first match must win.
            for (int k = 0; k < len; k++) begin
                if (k > 0 && $urandom_range(0, 5) == 0) begin
                    keys.push_back(keys[$urandom_range(0, k - 1)]);
                end else begin
                    keys.push_back($urandom);
                end
                order.push_back(k);
            end
            // The tail normally ends the list; sometimes it is a bad pointer or a cycle.
            sel = $urandom_range(0, 9);
            if (sel < 8) begin
                tail = lts_pkg::END_MARK;
            end else if (sel == 8) begin
                tail = PTR_W'($urandom_range(ENTRIES, 16'hFFFE));
            end else begin
                tail = PTR_W'(nodes[$urandom_range(0, len - 1)]);
            end

            for (int k = len - 1; k > 0; k--) begin
                pick = $urandom_range(0, k);
                swap = order[k];
                order[k] = order[pick];
                order[pick] = swap;
            end
            for (int k = 0; k < len; k++) begin
                pos = order[k];
                issue_write(nodes[pos], keys[pos][31:16], keys[pos][15:0],
                            (pos == len - 1) ? tail : PTR_W'(nodes[pos + 1]));
                if ($urandom_range(0, 4) == 0) begin
                    issue_write(IDX_W'($urandom_range(0, ENTRIES - 1)), KEY_W'($urandom),
                                KEY_W'($urandom),
                                $urandom_range(0, 1) ? lts_pkg::END_MARK : PTR_W'($urandom));
                end
            end

            nsearch = $urandom_range(4, 12);
            repeat (nsearch) begin
                pick = $urandom_range(0, len - 1);
                sel = $urandom_range(0, 19);
                if (sel < 10) begin
                    issue_search(node_hi[nodes[pick]], node_lo[nodes[pick]]);
                end else if (sel < 14) begin
                    issue_search(KEY_W'($urandom), KEY_W'($urandom));
                end else if (sel < 17) begin
                    issue_search(node_hi[nodes[pick]], KEY_W'($urandom));
                end else begin
                    issue_write(IDX_W'($urandom_range(0, ENTRIES - 1)), KEY_W'($urandom),
                                KEY_W'($urandom),
                                $urandom_range(0, 1) ? lts_pkg::END_MARK : PTR_W'($urandom));
                end
            end
            phase++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        // Keep the clock running to catch any stray result.
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
